// ----- rtl/rlq_pkg.sv -----
// ----------------------------------------------------------------------------
// rlq_pkg: shared types and constants for the range LCM table query block
// Widths, status codes, sequencer states and the arithmetic unit interface.
// ----------------------------------------------------------------------------
package rlq_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int IDX_W       = 9;
   localparam int VAL_W       = 32;
   localparam int LCM_W       = 63;
   localparam int CNT_W       = $clog2(LCM_W + 1);

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_VALUE = 3'd1,
      ST_FULL      = 3'd2,
      ST_BAD_INDEX = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ARITH_DIV_LONG,
      ARITH_DIV_SHORT,
      ARITH_MUL
   } arith_op_type;

   typedef struct packed {
      logic         go;
      arith_op_type op;
   } arith_req_type;

   typedef struct packed {
      logic done;
      logic overflow;
   } arith_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIRST_WAIT,
      S_FIRST_DATA,
      S_NEXT_WAIT,
      S_NEXT_DATA,
      S_MOD_WAIT,
      S_GCD_CHECK,
      S_GCD_WAIT,
      S_QUOT_WAIT,
      S_MUL_WAIT
   } state_type;

endpackage

// ----- rtl/rlq_arith.sv -----
// ----------------------------------------------------------------------------
// rlq_arith: iterative divide / multiply engine
// One 64-bit adder shared by restoring division and shift-add multiply,
// one bit per cycle.
// ----------------------------------------------------------------------------
module rlq_arith import rlq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  arith_req_type       arith_req,
   input  logic [LCM_W-1:0]    dp_a,
   input  logic [VAL_W-1:0]    dp_b,
   output arith_rsp_type       arith_rsp,
   output logic [LCM_W-1:0]    dp_num,
   output logic [VAL_W-1:0]    dp_rem
);

   logic                run_ff,   run_in;
   logic                done_ff,  done_in;
   logic                ovf_ff,   ovf_in;
   logic                mul_ff,   mul_in;
   logic [CNT_W-1:0]    cnt_ff,   cnt_in;
   logic [LCM_W-1:0]    num_ff,   num_in;
   logic [LCM_W-1:0]    mcand_ff, mcand_in;
   logic [VAL_W-1:0]    rem_ff,   rem_in;
   logic [VAL_W-1:0]    den_ff,   den_in;

   logic [VAL_W:0]      rp;
   logic [63:0]         add_x, add_y;
   logic                add_cin;
   logic [64:0]         sum;
   logic                ge;

   // shared adder: subtract for divide, accumulate for multiply
   always_comb begin
      rp = {rem_ff, num_ff[LCM_W-1]};
      if (mul_ff) begin
         add_x   = {num_ff, 1'b0};
         add_y   = den_ff[VAL_W-1] ? {1'b0, mcand_ff} : 64'd0;
         add_cin = 1'b0;
      end else begin
         add_x   = {{(64-VAL_W-1){1'b0}}, rp};
         add_y   = ~{{(64-VAL_W){1'b0}}, den_ff};
         add_cin = 1'b1;
      end
      sum = {1'b0, add_x} + {1'b0, add_y} + {64'd0, add_cin};
      ge  = sum[64];
   end

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      ovf_in   = ovf_ff;
      mul_in   = mul_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      mcand_in = mcand_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (arith_req.go) begin
         run_in = 1'b1;
         ovf_in = 1'b0;
         rem_in = '0;
         case (arith_req.op)
            ARITH_DIV_LONG: begin
               mul_in = 1'b0;
               cnt_in = CNT_W'(LCM_W);
               num_in = dp_a;
               den_in = dp_b;
            end
            ARITH_DIV_SHORT: begin
               mul_in = 1'b0;
               cnt_in = CNT_W'(VAL_W);
               num_in = {dp_a[VAL_W-1:0], {(LCM_W-VAL_W){1'b0}}};
               den_in = dp_b;
            end
            ARITH_MUL: begin
               mul_in   = 1'b1;
               cnt_in   = CNT_W'(VAL_W);
               num_in   = '0;
               mcand_in = dp_a;
               den_in   = dp_b;
            end
            default: begin
               run_in = 1'b0;
            end
         endcase
      end else if (run_ff) begin
         if (mul_ff) begin
            num_in = sum[LCM_W-1:0];
            ovf_in = ovf_ff | sum[64] | sum[63];
            den_in = {den_ff[VAL_W-2:0], 1'b0};
         end else begin
            rem_in = ge ? sum[VAL_W-1:0] : rp[VAL_W-1:0];
            num_in = {num_ff[LCM_W-2:0], ge};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         mul_ff  <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         mul_ff  <= mul_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff   <= ovf_in;
      num_ff   <= num_in;
      mcand_ff <= mcand_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
   end

   assign arith_rsp.done     = done_ff;
   assign arith_rsp.overflow = ovf_ff;
   assign dp_num             = num_ff;
   assign dp_rem             = rem_ff;

endmodule

// ----- rtl/range_lcm_table_query.sv -----
// ----------------------------------------------------------------------------
// range_lcm_table_query: count table with range least-common-multiple query
// Appends fill a table; queries fold the LCM over an index range with a
// shared iterative divide / multiply unit.
// ----------------------------------------------------------------------------
// Append and rejected query answer on the cycle after the beat; a query
//   reads its first entry, then for each further entry runs acc mod b,
//   the Euclid steps, a divide of acc by the gcd and a multiply.
// Throughput: appends back to back, busy stays low; a query holds busy until
//   the cycle of its result strobe. The receiver cannot stall.
// Reset clears the fill count, sequencer and strobe; table contents persist.
// ----------------------------------------------------------------------------
module range_lcm_table_query import rlq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_cmd,
   input  logic [VAL_W-1:0]   req_value,
   input  logic [IDX_W-1:0]   req_first_index,
   input  logic [IDX_W-1:0]   req_end_index,
   output logic               rsp_valid,
   output logic [LCM_W-1:0]   rsp_lcm_value,
   output logic [2:0]         rsp_status
);

   // count storage, one write port (append) and one registered read port
   logic [VAL_W-1:0]  cnt_mem [TABLE_DEPTH];
   logic [VAL_W-1:0]  rd_data_ff;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  entry_count_ff, entry_count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  end_ff, end_in;
   logic [LCM_W-1:0]  acc_ff, acc_in;      // running LCM
   logic [VAL_W-1:0]  b_ff, b_in;          // current entry
   logic [VAL_W-1:0]  gx_ff, gx_in;        // Euclid pair
   logic [VAL_W-1:0]  gy_ff, gy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LCM_W-1:0]  rsp_lcm_ff, rsp_lcm_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              accept;
   logic              mem_we;
   logic              bad_index;
   logic [IDX_W-1:0]  idx_next;

   arith_req_type     arith_req;
   arith_rsp_type     arith_rsp;
   logic [LCM_W-1:0]  dp_a;
   logic [VAL_W-1:0]  dp_b;
   logic [LCM_W-1:0]  dp_num;
   logic [VAL_W-1:0]  dp_rem;

   rlq_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .arith_req (arith_req),
      .dp_a      (dp_a),
      .dp_b      (dp_b),
      .arith_rsp (arith_rsp),
      .dp_num    (dp_num),
      .dp_rem    (dp_rem)
   );

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start & ~busy;
   assign idx_next = idx_ff + IDX_W'(1);

   // range check against the fill count at the time of the beat
   assign bad_index = (req_first_index > req_end_index) ||
                      (req_end_index > entry_count_ff) ||
                      ((req_first_index == req_end_index) &&
                       (req_first_index >= entry_count_ff));

   assign mem_we = accept && !req_cmd && (req_value != '0) &&
                   (entry_count_ff < IDX_W'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cnt_mem[entry_count_ff[ADDR_W-1:0]] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= cnt_mem[idx_ff[ADDR_W-1:0]];
   end

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      idx_in         = idx_ff;
      end_in         = end_ff;
      acc_in         = acc_ff;
      b_in           = b_ff;
      gx_in          = gx_ff;
      gy_in          = gy_ff;
      rsp_valid_in   = 1'b0;
      rsp_lcm_in     = rsp_lcm_ff;
      rsp_status_in  = rsp_status_ff;
      arith_req.go   = 1'b0;
      arith_req.op   = ARITH_DIV_LONG;
      dp_a           = acc_ff;
      dp_b           = b_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!req_cmd) begin
                  // append answers at once
                  rsp_valid_in = 1'b1;
                  rsp_lcm_in   = '0;
                  if (req_value == '0) begin
                     rsp_status_in = ST_BAD_VALUE;
                  end else if (!mem_we) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     rsp_status_in  = ST_OK;
                     entry_count_in = entry_count_ff + IDX_W'(1);
                  end
               end else if (bad_index) begin
                  rsp_valid_in  = 1'b1;
                  rsp_lcm_in    = '0;
                  rsp_status_in = ST_BAD_INDEX;
               end else begin
                  idx_in   = req_first_index;
                  end_in   = req_end_index;
                  state_in = S_FIRST_WAIT;
               end
            end
         end
         S_FIRST_WAIT: begin
            state_in = S_FIRST_DATA;
         end
         S_FIRST_DATA: begin
            if (idx_ff == end_ff) begin
               // single-entry query
               rsp_valid_in  = 1'b1;
               rsp_lcm_in    = {{(LCM_W-VAL_W){1'b0}}, rd_data_ff};
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end else begin
               acc_in = {{(LCM_W-VAL_W){1'b0}}, rd_data_ff};
               idx_in = idx_next;
               if (idx_next == end_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_lcm_in    = {{(LCM_W-VAL_W){1'b0}}, rd_data_ff};
                  rsp_status_in = ST_OK;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_NEXT_WAIT;
               end
            end
         end
         S_NEXT_WAIT: begin
            state_in = S_NEXT_DATA;
         end
         S_NEXT_DATA: begin
            // acc mod b opens the Euclid chain
            b_in         = rd_data_ff;
            arith_req.go = 1'b1;
            arith_req.op = ARITH_DIV_LONG;
            dp_a         = acc_ff;
            dp_b         = rd_data_ff;
            state_in     = S_MOD_WAIT;
         end
         S_MOD_WAIT: begin
            if (arith_rsp.done) begin
               gx_in    = b_ff;
               gy_in    = dp_rem;
               state_in = S_GCD_CHECK;
            end
         end
         S_GCD_CHECK: begin
            arith_req.go = 1'b1;
            if (gy_ff == '0) begin
               // gcd found in gx: divide it out of acc
               arith_req.op = ARITH_DIV_LONG;
               dp_a         = acc_ff;
               dp_b         = gx_ff;
               state_in     = S_QUOT_WAIT;
            end else begin
               arith_req.op = ARITH_DIV_SHORT;
               dp_a         = {{(LCM_W-VAL_W){1'b0}}, gx_ff};
               dp_b         = gy_ff;
               state_in     = S_GCD_WAIT;
            end
         end
         S_GCD_WAIT: begin
            if (arith_rsp.done) begin
               gx_in    = gy_ff;
               gy_in    = dp_rem;
               state_in = S_GCD_CHECK;
            end
         end
         S_QUOT_WAIT: begin
            if (arith_rsp.done) begin
               arith_req.go = 1'b1;
               arith_req.op = ARITH_MUL;
               dp_a         = dp_num;
               dp_b         = b_ff;
               state_in     = S_MUL_WAIT;
            end
         end
         S_MUL_WAIT: begin
            if (arith_rsp.done) begin
               if (arith_rsp.overflow) begin
                  rsp_valid_in  = 1'b1;
                  rsp_lcm_in    = '0;
                  rsp_status_in = ST_OVERFLOW;
                  state_in      = S_IDLE;
               end else begin
                  acc_in = dp_num;
                  idx_in = idx_next;
                  if (idx_next == end_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_lcm_in    = dp_num;
                     rsp_status_in = ST_OK;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_NEXT_WAIT;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      end_ff        <= end_in;
      acc_ff        <= acc_in;
      b_ff          <= b_in;
      gx_ff         <= gx_in;
      gy_ff         <= gy_in;
      rsp_lcm_ff    <= rsp_lcm_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lcm_value = rsp_lcm_ff;
   assign rsp_status    = rsp_status_ff;

   // error beats always carry a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_lcm_value == '0))
      else $error("error response with nonzero value");

   // fill count never passes the table depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= IDX_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // an append is answered on the next cycle
   a_append_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_cmd |=> rsp_valid)
      else $error("append not answered");

   // the arithmetic unit only finishes while the sequencer waits for it
   a_done_state: assert property (@(posedge clock) disable iff (reset)
      arith_rsp.done |-> (state_ff == S_MOD_WAIT) || (state_ff == S_GCD_WAIT) ||
                         (state_ff == S_QUOT_WAIT) || (state_ff == S_MUL_WAIT))
      else $error("arith done outside a wait state");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for range_lcm_table_query
// Drives append and range query beats through the start/busy handshake,
// predicts every answer from a private copy of the table and compares each
// rsp_valid strobe against the oldest pending answer.
// ----------------------------------------------------------------------------
module tb_top;
   import rlq_pkg::*;

   // Command codes of req_cmd
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   localparam longint unsigned LCM_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

   // Random phase length and how many beats must hit the full table
   localparam int RANDOM_BEATS   = 250;
   localparam int FULL_BEATS     = 15;
   localparam int PAUSE_AT_BEAT  = 120;
   // Cycles with neither a beat nor a result before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 2_000_000;
   // Appends answer on the cycle after the beat; the window catches stray strobes
   localparam int DRAIN_CYCLES   = 16;

   typedef struct packed {
      logic [LCM_W-1:0] lcm;
      status_type       status;
   } answer_t;

   // One row of the directed stimulus; typed rows carry their own answer
   typedef struct packed {
      logic             cmd;
      logic [VAL_W-1:0] value;
      logic [IDX_W-1:0] first_idx;
      logic [IDX_W-1:0] end_idx;
      logic             typed;
      logic [LCM_W-1:0] lcm;
      status_type       status;
   } dir_row_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_cmd = CMD_APPEND;
   logic [VAL_W-1:0]   req_value = '0;
   logic [IDX_W-1:0]   req_first_index = '0;
   logic [IDX_W-1:0]   req_end_index = '0;
   logic               rsp_valid;
   logic [LCM_W-1:0]   rsp_lcm_value;
   logic [2:0]         rsp_status;

   // Predictor state: shadow of the count table and its fill level
   logic [VAL_W-1:0]   table_copy [TABLE_DEPTH];
   int                 fill_count = 0;

   answer_t            pending_answers [$];
   int                 error_count = 0;
   int                 idle_cycles = 0;
   int                 burst_left = 0;

   // Directed rows. Table contents after row 18:
   //   [0]=FFFFFFFF [1]=FFFFFFFE [2]=1 [3]=12 [4]=18 [5]=2^31 [6]=2^30
   dir_row_t directed_rows [25] = '{
      // empty table: any query is refused, even the equal pair at zero
      '{CMD_QUERY,  32'd0,         9'd0,   9'd0,   1'b1, 63'd0, ST_BAD_INDEX},
      '{CMD_QUERY,  32'hFFFF_FFFF, 9'd0,   9'd1,   1'b1, 63'd0, ST_BAD_INDEX},
      // zero count is refused and leaves the table alone
      '{CMD_APPEND, 32'd0,         9'd0,   9'd0,   1'b1, 63'd0, ST_BAD_VALUE},
      '{CMD_APPEND, 32'hFFFF_FFFF, 9'h1FF, 9'h1FF, 1'b1, 63'd0, ST_OK},
      // equal pair returns the entry itself
      '{CMD_QUERY,  32'd0,         9'd0,   9'd0,   1'b1, 63'hFFFF_FFFF, ST_OK},
      '{CMD_APPEND, 32'hFFFF_FFFE, 9'd0,   9'd0,   1'b1, 63'd0, ST_OK},
      // coprime near-max pair: product passes 63 bits
      '{CMD_QUERY,  32'd0,         9'd0,   9'd2,   1'b1, 63'd0, ST_OVERFLOW},
      // first past end, equal pair past the fill, all-ones indices
      '{CMD_QUERY,  32'd0,         9'd1,   9'd0,   1'b1, 63'd0, ST_BAD_INDEX},
      '{CMD_QUERY,  32'd0,         9'd2,   9'd2,   1'b1, 63'd0, ST_BAD_INDEX},
      '{CMD_QUERY,  32'd0,         9'h1FF, 9'h1FF, 1'b1, 63'd0, ST_BAD_INDEX},
      '{CMD_APPEND, 32'd1,         9'd0,   9'd0,   1'b0, 63'd0, ST_OK},
      '{CMD_APPEND, 32'd12,        9'd0,   9'd0,   1'b0, 63'd0, ST_OK},
      '{CMD_APPEND, 32'd18,        9'd0,   9'd0,   1'b0, 63'd0, ST_OK},
      '{CMD_QUERY,  32'd0,         9'd2,   9'd5,   1'b0, 63'd0, ST_OK},
      '{CMD_QUERY,  32'd0,         9'd3,   9'd4,   1'b0, 63'd0, ST_OK},
      '{CMD_QUERY,  32'd0,         9'd1,   9'd1,   1'b1, 63'hFFFF_FFFE, ST_OK},
      '{CMD_APPEND, 32'h8000_0000, 9'd0,   9'd0,   1'b0, 63'd0, ST_OK},
      '{CMD_APPEND, 32'h4000_0000, 9'd0,   9'd0,   1'b0, 63'd0, ST_OK},
      '{CMD_QUERY,  32'd0,         9'd5,   9'd7,   1'b0, 63'd0, ST_OK},
      '{CMD_QUERY,  32'hFFFF_FFFF, 9'd0,   9'd7,   1'b0, 63'd0, ST_OK},
      '{CMD_QUERY,  32'd0,         9'd4,   9'd4,   1'b0, 63'd0, ST_OK},
      '{CMD_QUERY,  32'd0,         9'd2,   9'd6,   1'b0, 63'd0, ST_OK},
      // equal pair right at the fill level, end one past the fill
      '{CMD_QUERY,  32'd0,         9'd7,   9'd7,   1'b1, 63'd0, ST_BAD_INDEX},
      '{CMD_QUERY,  32'd0,         9'd0,   9'd8,   1'b1, 63'd0, ST_BAD_INDEX},
      '{CMD_QUERY,  32'd0,         9'd6,   9'd7,   1'b0, 63'd0, ST_OK}
   };

   range_lcm_table_query dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .req_first_index (req_first_index),
      .req_end_index   (req_end_index),
      .rsp_valid       (rsp_valid),
      .rsp_lcm_value   (rsp_lcm_value),
      .rsp_status      (rsp_status)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic longint unsigned gcd_of(input longint unsigned a,
                                              input longint unsigned b);
      longint unsigned r;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      return a;
   endfunction

   // Works out the answer to one accepted beat and applies its side effect
   // on the shadow table.
   function automatic answer_t predict_answer(input logic cmd,
                                              input logic [VAL_W-1:0] val,
                                              input logic [IDX_W-1:0] f_idx,
                                              input logic [IDX_W-1:0] e_idx);
      answer_t         ans;
      longint unsigned acc;
      longint unsigned term;
      longint unsigned quot;
      int              i;
      logic            ovf;
      ans.lcm    = '0;
      ans.status = ST_OK;
      ovf        = 1'b0;
      if (cmd == CMD_APPEND) begin
         // zero check wins over the full check
         if (val == '0) begin
            ans.status = ST_BAD_VALUE;
         end else if (fill_count >= TABLE_DEPTH) begin
            ans.status = ST_FULL;
         end else begin
            table_copy[fill_count] = val;
            fill_count++;
         end
      end else if (f_idx > e_idx || int'(e_idx) > fill_count ||
                   (f_idx == e_idx && int'(f_idx) >= fill_count)) begin
         ans.status = ST_BAD_INDEX;
      end else if (f_idx == e_idx) begin
         ans.lcm = LCM_W'(table_copy[f_idx]);
      end else begin
         // left-to-right fold; stop at the first step that passes 63 bits
         acc = table_copy[f_idx];
         for (i = int'(f_idx) + 1; i < int'(e_idx) && !ovf; i++) begin
            term = table_copy[i];
            quot = acc / gcd_of(acc, term);
            if (quot > LCM_LIMIT / term) ovf = 1'b1;
            else acc = quot * term;
         end
         if (ovf) ans.status = ST_OVERFLOW;
         else ans.lcm = acc[LCM_W-1:0];
      end
      return ans;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // Idle cycles before the next beat: mostly none or short, a few long,
   // and now and then a back-to-back burst.
   function automatic int pick_gap();
      int sel;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
         burst_left = $urandom_range(8, 20);
         return 0;
      end else if (sel < 40) return 0;
      else if (sel < 85) return $urandom_range(1, 3);
      else if (sel < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // Counts lean small so that range folds go several entries deep before
   // overflowing; near-max and full random values toggle the upper bits.
   function automatic logic [VAL_W-1:0] pick_count();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 5) return '0;
      else if (sel < 45) return VAL_W'($urandom_range(1, 16));
      else if (sel < 65) return VAL_W'($urandom_range(1, 360));
      else if (sel < 75) return VAL_W'(1) << $urandom_range(0, 31);
      else if (sel < 85) return 32'hFFFF_FFFF - VAL_W'($urandom_range(0, 3));
      else return $urandom();
   endfunction

   // Query indices: mostly short valid ranges or equal pairs, a few long
   // ranges to the fill level, the rest edge cases and noise.
   task automatic pick_range(output logic [IDX_W-1:0] f_idx,
                             output logic [IDX_W-1:0] e_idx);
      int sel;
      int f;
      int span;
      sel = $urandom_range(0, 99);
      if (fill_count > 0 && sel < 75) begin
         f    = $urandom_range(0, fill_count - 1);
         span = $urandom_range(0, 6);
         if (span > fill_count - f) span = fill_count - f;
         f_idx = IDX_W'(f);
         e_idx = IDX_W'(f + span);
      end else if (fill_count > 1 && sel < 79) begin
         f = $urandom_range(0, 3);
         if (f >= fill_count) f = 0;
         f_idx = IDX_W'(f);
         e_idx = IDX_W'(fill_count);
      end else if (sel < 90) begin
         // right at or just past the fill level
         f_idx = IDX_W'(fill_count + $urandom_range(0, 1));
         e_idx = IDX_W'(fill_count + $urandom_range(0, 1));
      end else begin
         f_idx = IDX_W'($urandom_range(0, 511));
         e_idx = IDX_W'($urandom_range(0, 511));
      end
   endtask

   // Presents one beat, waits for the handshake and records the answer.
   // start is left high so a zero gap gives back-to-back beats.
   task automatic send_beat(input logic cmd, input logic [VAL_W-1:0] val,
                            input logic [IDX_W-1:0] f_idx,
                            input logic [IDX_W-1:0] e_idx,
                            input logic use_typed, input answer_t typed_ans);
      int      gap;
      answer_t predicted;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_cmd         <= cmd;
      req_value       <= val;
      req_first_index <= f_idx;
      req_end_index   <= e_idx;
      start           <= 1'b1;
      // busy read here is its value at this edge, before the DUT updates
      do @(posedge clock); while (busy !== 1'b0);
      predicted = predict_answer(cmd, val, f_idx, e_idx);
      pending_answers.push_back(use_typed ? typed_ans : predicted);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int               i;
      int               rand_sent;
      int               full_sent;
      dir_row_t         row;
      answer_t          typed_ans;
      logic             cmd;
      logic [VAL_W-1:0] val;
      logic [IDX_W-1:0] f_idx;
      logic [IDX_W-1:0] e_idx;

      rand_sent = 0;
      full_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part
      for (i = 0; i < $size(directed_rows); i++) begin
         row              = directed_rows[i];
         typed_ans.lcm    = row.lcm;
         typed_ans.status = row.status;
         send_beat(row.cmd, row.value, row.first_idx, row.end_idx,
                   row.typed, typed_ans);
      end

      // Random part: appends dominate until the table is full, then mostly
      // queries against the full table plus appends that must be refused.
      typed_ans = '0;
      while (rand_sent < RANDOM_BEATS || full_sent < FULL_BEATS) begin
         if (rand_sent == PAUSE_AT_BEAT) begin
            // hold off until every outstanding answer is back
            start <= 1'b0;
            @(posedge clock);
            while (pending_answers.size() != 0) @(posedge clock);
         end
         if (fill_count >= TABLE_DEPTH) full_sent++;
         if (fill_count < TABLE_DEPTH) cmd = ($urandom_range(0, 99) < 95) ?
                                             CMD_APPEND : CMD_QUERY;
         else cmd = ($urandom_range(0, 99) < 30) ? CMD_APPEND : CMD_QUERY;
         if (cmd == CMD_APPEND) begin
            val   = pick_count();
            f_idx = IDX_W'($urandom_range(0, 511));
            e_idx = IDX_W'($urandom_range(0, 511));
         end else begin
            val = $urandom();
            pick_range(f_idx, e_idx);
         end
         send_beat(cmd, val, f_idx, e_idx, 1'b0, typed_ans);
         rand_sent++;
      end

      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      // any stray strobe in this window is flagged by the checker
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Answer checker: every strobe is matched against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_answers
      answer_t oldest;
      if (rsp_valid === 1'b1) begin
         if (pending_answers.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, lcm %0h rsp_status %0d", $time,
                     rsp_lcm_value, rsp_status);
         end else begin
            oldest = pending_answers.pop_front();
            if (rsp_lcm_value !== oldest.lcm) begin
               error_count++;
               $display("%0t: rsp_lcm_value mismatch, expected %0h, got %0h",
                        $time, oldest.lcm, rsp_lcm_value);
            end
            if (rsp_status !== oldest.status) begin
               error_count++;
               $display("%0t: rsp_status mismatch, expected %0d, got %0d",
                        $time, oldest.status, rsp_status);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: any beat or result restarts the count
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, idle_cycles);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
